FILE: sv/mlrs_pkg.sv
package mlrs_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = 6;

  localparam logic [31:0] THRESH_RESET  = 32'd8000;
  localparam logic [41:0] CEILING_RESET = 42'd1000000;

  localparam logic [0:0] OP_WRITE  = 1'b0;
  localparam logic [0:0] OP_SELECT = 1'b1;

  localparam logic [0:0] REG_THRESH  = 1'b0;
  localparam logic [0:0] REG_CEILING = 1'b1;

  localparam logic [1:0] LVL_RR    = 2'd1;
  localparam logic [1:0] LVL_LOT   = 2'd2;
  localparam logic [1:0] LVL_RANK  = 2'd3;

  // slot record as stored in RAM
  typedef struct packed {
    logic [7:0]  cw;
    logic [7:0]  pw;
    logic [7:0]  aw;
    logic [31:0] cycles;
    logic [31:0] arrival;
    logic [15:0] prio;
    logic [15:0] tickets;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PROMO,
    ST_RR,
    ST_SUM,
    ST_DIV,
    ST_LOT,
    ST_RANK_RD,
    ST_RANK_M1,
    ST_RANK_M2,
    ST_RANK_M3,
    ST_DONE,
    ST_OUT
  } state_t;

endpackage

FILE: sv/mlrs_ram.sv
module mlrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mlrs_divider.sv
// restoring divider, one quotient bit per cycle, remainder only
module mlrs_divider import mlrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [21:0] divisor,
  output logic        done,
  output logic [21:0] remainder
);

  logic [31:0] quo;
  logic [22:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic [22:0] shifted;

  assign shifted = {rem[21:0], quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        quo  <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (shifted >= {1'b0, divisor}) begin
          rem <= shifted - {1'b0, divisor};
        end else begin
          rem <= shifted;
        end
        quo <= {quo[30:0], 1'b0};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[21:0];

endmodule

FILE: sv/multilevel_lottery_rank_scheduler.sv
// Multilevel queue scheduler over 64 task slots. Write items (opcode 0) fill
// a slot; the all-zero result is offered the cycle after the input transfer and
// the next input is taken the cycle after the result transfer. Select items
// (opcode 1) run a sequencer over the slot RAM: a promotion pass and a
// round-robin pass; unless a level has won, a ticket sum pass; if the total is
// nonzero, a draw mod total remainder and a lottery pass; and, unless a level
// has won, a rank pass that visits each slot and runs three 32x8 multiplies on
// each runnable level-3 slot. A select with 64 rank candidates is the worst
// case; an early level win ends sooner. After reset a clearing pass zeroes the
// table; input is not taken meanwhile. Runnable and level flags live in
// flip-flops; the wide fields live in one RAM. One transfer in, one transfer
// out per item.
module multilevel_lottery_rank_scheduler import mlrs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [41:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // opcode, slot, runnable, level, tickets, priority_req, arrival, cycles,
  // arrival_weight, priority_weight, cycles_weight, draw (lowest bit first)
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // found, chosen_slot, served_level, chosen_rank (lowest bit first)
  output logic [55:0]  m_tdata
);

  // input fields
  logic        in_op;
  logic [5:0]  in_slot;
  logic        in_run;
  logic [1:0]  in_lvl;
  slot_rec_t   in_rec;
  logic [31:0] in_draw;

  assign in_op          = s_tdata[0];
  assign in_slot        = s_tdata[6:1];
  assign in_run         = s_tdata[7];
  assign in_lvl         = s_tdata[9:8];
  assign in_rec.tickets = s_tdata[25:10];
  assign in_rec.prio    = s_tdata[41:26];
  assign in_rec.arrival = s_tdata[73:42];
  assign in_rec.cycles  = s_tdata[105:74];
  assign in_rec.aw      = s_tdata[113:106];
  assign in_rec.pw      = s_tdata[121:114];
  assign in_rec.cw      = s_tdata[129:122];
  assign in_draw        = s_tdata[161:130];

  logic [31:0] thresh;
  logic [41:0] ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh  <= THRESH_RESET;
      ceiling <= CEILING_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESH:  thresh  <= cfg_data[31:0];
        REG_CEILING: ceiling <= cfg_data;
        default: ;
      endcase
    end
  end

  // flag arrays, fixed-place per-slot bits
  logic [SLOT_COUNT-1:0] run_f;
  logic [1:0]            lvl_f [SLOT_COUNT];

  state_t      state, state_next;
  logic [6:0]  idx;          // pass counter, bit 6 marks end of pass
  logic [5:0]  rr_next;
  logic [31:0] draw;
  logic [21:0] total;
  logic [21:0] base;
  logic [21:0] tval;
  logic [41:0] best;
  logic [41:0] acc;
  logic [5:0]  cur;          // slot whose data is on rdata
  logic        cur_ok;       // a read for cur was issued last cycle
  logic        found;
  logic [5:0]  chosen;
  logic [1:0]  served;
  logic [41:0] rank;
  logic        div_start, div_done;
  logic [21:0] div_rem;

  // RAM ports
  logic        ram_we;
  logic [5:0]  ram_waddr, ram_raddr;
  slot_rec_t   ram_wdata, ram_rdata;

  mlrs_ram #(.WIDTH(REC_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mlrs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (draw),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  logic [5:0] rr_slot;
  assign rr_slot = rr_next + idx[5:0];

  // shared multiplier: 32x8
  logic [31:0] mul_a;
  logic [7:0]  mul_b;
  logic [39:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic cand2, cand3;
  assign cand2 = run_f[cur] && (lvl_f[cur] == LVL_LOT);
  assign cand3 = run_f[cur] && (lvl_f[cur] == LVL_RANK);

  // rank multiply steps keep cur and re-read its record
  logic [5:0] pass_addr;
  assign pass_addr = (state == ST_RR) ? rr_slot :
                     (state == ST_RANK_M1 || state == ST_RANK_M2 ||
                      state == ST_RANK_M3) ? cur : idx[5:0];

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx[5:0];
    ram_wdata  = '0;
    ram_raddr  = pass_addr;
    div_start  = 1'b0;
    mul_a      = ram_rdata.prio[15:0] == 16'd0 ? 32'd0 : {16'd0, ram_rdata.prio};
    mul_b      = ram_rdata.pw;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (idx == 7'd63) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_op == OP_WRITE) begin
            ram_we     = 1'b1;
            ram_waddr  = in_slot;
            ram_wdata  = in_rec;
            state_next = ST_OUT;
          end else begin
            state_next = ST_PROMO;
          end
        end
      end
      ST_PROMO: if (idx[6]) state_next = ST_RR;
      ST_RR: begin
        if (cur_ok && run_f[cur] && lvl_f[cur] == LVL_RR) begin
          if (ram_rdata.cycles >= thresh) begin
            ram_we    = 1'b1;
            ram_waddr = cur;
            ram_wdata = ram_rdata;
            ram_wdata.cycles = '0;
          end
          state_next = ST_DONE;
        end else if (idx[6]) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        // decide once the last slot's tickets are in the total
        if (idx[6] && !cur_ok) begin
          state_next = (total == 22'd0) ? ST_RANK_RD : ST_DIV;
          div_start  = (total != 22'd0);
        end
      end
      ST_DIV: if (div_done) state_next = ST_LOT;
      ST_LOT: begin
        if (cur_ok && cand2 && tval < base + {6'd0, ram_rdata.tickets}) begin
          state_next = ST_DONE;
        end else if (idx[6]) begin
          state_next = ST_RANK_RD;
        end
      end
      ST_RANK_RD: begin
        if (idx[6]) begin
          state_next = ST_DONE;
        end else if (run_f[idx[5:0]] && lvl_f[idx[5:0]] == LVL_RANK) begin
          state_next = ST_RANK_M1;
        end
      end
      ST_RANK_M1: begin
        ram_raddr  = cur;
        mul_a      = {16'd0, ram_rdata.prio};
        mul_b      = ram_rdata.pw;
        state_next = ST_RANK_M2;
      end
      ST_RANK_M2: begin
        ram_raddr  = cur;
        mul_a      = ram_rdata.arrival;
        mul_b      = ram_rdata.aw;
        state_next = ST_RANK_M3;
      end
      ST_RANK_M3: begin
        mul_a      = ram_rdata.cycles;
        mul_b      = ram_rdata.cw;
        state_next = ST_RANK_RD;
      end
      ST_DONE: state_next = ST_OUT;
      ST_OUT:  if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {5'd0, rank, served, chosen, found};

  // datapath and pass sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      run_f   <= '0;
      lvl_f   <= '{default: 2'd0};
      rr_next <= '0;
      idx     <= '0;
      cur_ok  <= 1'b0;
      found   <= 1'b0;
      chosen  <= '0;
      served  <= '0;
      rank    <= '0;
    end else begin
      cur    <= pass_addr;
      cur_ok <= 1'b0;
      unique case (state)
        ST_CLEAR: idx <= idx + 7'd1;
        ST_IDLE: begin
          idx <= '0;
          if (s_tvalid) begin
            found  <= 1'b0;
            chosen <= '0;
            served <= '0;
            rank   <= '0;
            draw   <= in_draw;
            total  <= '0;
            base   <= '0;
            best   <= ceiling;
            if (in_op == OP_WRITE) begin
              run_f[in_slot] <= in_run;
              lvl_f[in_slot] <= in_lvl;
            end
          end
        end
        ST_PROMO: begin
          // read issued with idx, data lands next cycle for cur
          if (!idx[6]) begin
            idx    <= idx + 7'd1;
            cur_ok <= 1'b1;
          end
          if (cur_ok && ram_rdata.cycles >= thresh && lvl_f[cur] != 2'd0) begin
            lvl_f[cur] <= LVL_RR;
          end
          if (idx[6]) idx <= '0;
        end
        ST_RR: begin
          if (!idx[6]) begin
            idx    <= idx + 7'd1;
            cur_ok <= 1'b1;
          end
          if (cur_ok && run_f[cur] && lvl_f[cur] == LVL_RR) begin
            found   <= 1'b1;
            chosen  <= cur;
            served  <= LVL_RR;
            rr_next <= cur + 6'd1;
          end else if (idx[6]) begin
            idx <= '0;
          end
        end
        ST_SUM: begin
          if (!idx[6]) begin
            idx    <= idx + 7'd1;
            cur_ok <= 1'b1;
          end
          if (cur_ok && cand2) total <= total + {6'd0, ram_rdata.tickets};
          if (idx[6] && !cur_ok) idx <= '0;
        end
        ST_DIV: begin
          idx <= '0;
          if (div_done) tval <= div_rem;
        end
        ST_LOT: begin
          if (!idx[6]) begin
            idx    <= idx + 7'd1;
            cur_ok <= 1'b1;
          end
          if (cur_ok && cand2) begin
            if (tval < base + {6'd0, ram_rdata.tickets}) begin
              found  <= 1'b1;
              chosen <= cur;
              served <= LVL_LOT;
            end
            base <= base + {6'd0, ram_rdata.tickets};
          end
          if (idx[6]) begin
            idx  <= '0;
            best <= ceiling;
          end
        end
        ST_RANK_RD: begin
          // slots that are not rank candidates are skipped with no multiply steps
          if (!idx[6]) begin
            if (run_f[idx[5:0]] && lvl_f[idx[5:0]] == LVL_RANK) begin
              acc <= '0;
            end
            idx <= idx + 7'd1;
          end
        end
        ST_RANK_M1: begin
          acc <= {2'd0, mul_p};
          if (!cand3) idx <= idx;
        end
        ST_RANK_M2: acc <= acc + {2'd0, mul_p};
        ST_RANK_M3: begin
          if (cand3 && (acc + {2'd0, mul_p}) <= best) begin
            best   <= acc + {2'd0, mul_p};
            found  <= 1'b1;
            chosen <= cur;
            served <= LVL_RANK;
            rank   <= acc + {2'd0, mul_p};
          end
        end
        ST_DONE: if (found) run_f[chosen] <= 1'b0;
        ST_OUT: ;
        default: ;
      endcase
    end
  end

endmodule
